### design/fpa_pkg.sv
package fpa_pkg;

   localparam int unsigned MANT_W = 26;   // signed mantissa after sign apply
   localparam int unsigned SUM_W  = 27;   // aligned sum with two sign bits
   localparam int unsigned NORM_W = 25;   // normalize window, leading one at top
   localparam logic [7:0]  INT_EXP = 8'd150;

   typedef struct packed {
      logic        want_int;
      logic        bypass;
      logic [31:0] bypass_val;
      logic [7:0]  e0;
   } meta_type;

endpackage

### design/fpa_align.sv
module fpa_align (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [31:0]                    x_operand,
   input  logic [31:0]                    y_operand,
   input  logic                           x_is_integer,
   input  logic                           want_integer,
   output logic                           sum_valid,
   output fpa_pkg::meta_type              sum_meta,
   output logic [fpa_pkg::SUM_W-1:0]      sum_value
);

   logic                                 xs, ys;
   logic [24:0]                          xm, ym;
   logic [7:0]                           xe, ye, diff;
   logic signed [fpa_pkg::MANT_W-1:0]    x0_in, y0_in;
   logic                                 swap_in;
   logic [4:0]                           sh_in;
   fpa_pkg::meta_type                    meta_in;

   logic                                 s1_valid_ff;
   fpa_pkg::meta_type                    s1_meta_ff;
   logic signed [fpa_pkg::MANT_W-1:0]    s1_x0_ff, s1_y0_ff;
   logic                                 s1_swap_ff, s1_xs_ff, s1_ys_ff;
   logic [4:0]                           s1_sh_ff;

   logic signed [fpa_pkg::MANT_W-1:0]    x3, y3;
   logic [fpa_pkg::SUM_W-1:0]            sum_in;

   logic                                 s2_valid_ff;
   fpa_pkg::meta_type                    s2_meta_ff;
   logic [fpa_pkg::SUM_W-1:0]            s2_sum_ff;

   always_comb begin
      xs = x_operand[31];
      ys = y_operand[31];
      xm = {1'b1, x_operand[22:0], 1'b0};
      ym = {~x_is_integer & ~want_integer, y_operand[22:0], 1'b0};
      if (x_is_integer) begin
         xe    = fpa_pkg::INT_EXP;
         x0_in = {x_operand[23], x_operand[23:0], 1'b0};
      end else begin
         xe    = x_operand[30:23];
         x0_in = xs ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
      end
      ye    = y_operand[30:23];
      y0_in = ys ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
      swap_in = ye > xe;
      diff    = swap_in ? ye - xe : xe - ye;
      sh_in   = (diff > 8'd31) ? 5'd31 : diff[4:0];
      meta_in.want_int   = want_integer;
      meta_in.e0         = swap_in ? ye : xe;
      meta_in.bypass     = 1'b0;
      meta_in.bypass_val = '0;
      if (x_operand[30:0] == '0) begin
         meta_in.bypass     = 1'b1;
         meta_in.bypass_val = x_is_integer ? 32'd0 : y_operand;
      end else if (y_operand[30:0] == '0) begin
         meta_in.bypass     = 1'b1;
         meta_in.bypass_val = x_operand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_meta_ff <= meta_in;
         s1_x0_ff   <= x0_in;
         s1_y0_ff   <= y0_in;
         s1_swap_ff <= swap_in;
         s1_sh_ff   <= sh_in;
         s1_xs_ff   <= xs;
         s1_ys_ff   <= ys;
      end
   end

   // shift the smaller operand; wide shifts leave only sign copies
   always_comb begin
      x3 = s1_swap_ff ? (s1_x0_ff >>> s1_sh_ff) : s1_x0_ff;
      y3 = s1_swap_ff ? s1_y0_ff : (s1_y0_ff >>> s1_sh_ff);
      sum_in = {s1_xs_ff, s1_xs_ff, x3[24:0]} + {s1_ys_ff, s1_ys_ff, y3[24:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_meta_ff <= s1_meta_ff;
         s2_sum_ff  <= sum_in;
      end
   end

   assign sum_valid = s2_valid_ff;
   assign sum_meta  = s2_meta_ff;
   assign sum_value = s2_sum_ff;

endmodule

### design/fpa_norm.sv
module fpa_norm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           sum_valid,
   input  fpa_pkg::meta_type              sum_meta,
   input  logic [fpa_pkg::SUM_W-1:0]      sum_value,
   output logic                           out_valid,
   output logic [31:0]                    out_result
);

   logic [fpa_pkg::SUM_W-1:0]      mag, s_val;
   logic [4:0]                     lz_in;

   logic                           s3_valid_ff;
   fpa_pkg::meta_type              s3_meta_ff;
   logic                           s3_sign_ff;
   logic [fpa_pkg::NORM_W-1:0]     s3_t3_ff;
   logic [4:0]                     s3_lz_ff;
   logic [25:0]                    s3_int_ff;

   logic [fpa_pkg::NORM_W-1:0]     t3n;
   logic [9:0]                     e1;
   logic [31:0]                    result_in;

   logic                           s4_valid_ff;
   logic [31:0]                    s4_result_ff;

   // round by adding one; the search skips bit 0, which only matters when all else is zero
   always_comb begin
      mag   = sum_value[26] ? (~sum_value + 27'd1) : sum_value;
      s_val = mag + 27'd1;
      lz_in = 5'd24;
      for (int i = 1; i < fpa_pkg::NORM_W; i++) begin
         if (s_val[i + 1]) begin
            lz_in = 5'(24 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= sum_valid;
      end
      if (advance) begin
         s3_meta_ff <= sum_meta;
         s3_sign_ff <= sum_value[26];
         s3_t3_ff   <= s_val[25:1];
         s3_lz_ff   <= lz_in;
         s3_int_ff  <= sum_value[26:1];
      end
   end

   always_comb begin
      t3n = s3_t3_ff << s3_lz_ff;
      e1  = {2'b00, s3_meta_ff.e0} + 10'd1 - {5'd0, s3_lz_ff};
      if (s3_meta_ff.want_int) begin
         result_in = {{6{s3_int_ff[25]}}, s3_int_ff};
      end else if (s3_meta_ff.bypass) begin
         result_in = s3_meta_ff.bypass_val;
      end else if (t3n == '0 || e1[8]) begin
         result_in = 32'd0;
      end else begin
         result_in = {s3_sign_ff, e1[7:0], t3n[23:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_result_ff <= result_in;
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_result = s4_result_ff;

endmodule

### design/float_adder_with_conversions_top.sv
// Simplified single-precision adder with integer conversions.
// Request channel: req_valid/req_ready carry two 32-bit operands and two
// mode flags. req_x_is_integer reads x as a 24-bit signed integer with a
// fixed exponent; req_want_integer returns the aligned sum as an integer.
// Response channel: rsp_valid/rsp_ready carry one 32-bit rsp_result per
// request, in request order.
// Four register stages: decode and exponent compare, align and add,
// round and leading-one search, normalize and pack. The last stage is
// the output register. rsp_valid rises when the request reaches it.
// One request is accepted every cycle while responses are taken.
// When the receiver holds rsp_ready low with a response waiting, the
// whole pipeline freezes and req_ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline; no response is pending after it.
module float_adder_with_conversions_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_x_operand,
   input  logic [31:0] req_y_operand,
   input  logic        req_x_is_integer,
   input  logic        req_want_integer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result
);

   logic                           advance;
   logic                           sum_valid;
   fpa_pkg::meta_type              sum_meta;
   logic [fpa_pkg::SUM_W-1:0]      sum_value;

   assign advance   = ~rsp_valid | rsp_ready;
   assign req_ready = advance;

   fpa_align u_align (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .x_operand    (req_x_operand),
      .y_operand    (req_y_operand),
      .x_is_integer (req_x_is_integer),
      .want_integer (req_want_integer),
      .sum_valid    (sum_valid),
      .sum_meta     (sum_meta),
      .sum_value    (sum_value)
   );

   fpa_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sum_valid  (sum_valid),
      .sum_meta   (sum_meta),
      .sum_value  (sum_value),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("stalled response changed");

   a_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted during stall");

endmodule
